@@ src/lkk_pkg.sv @@
// lkk_pkg: shared types and constants for the light knob keystroke block
// holds state codes, modifier codes, beat layouts and configuration defaults
// no dependencies; used by the top level and its port checker
`default_nettype none

package lkk_pkg;

  // default stamp width, handed to the top level parameter
  localparam int TIME_WIDTH_DEF = 32;

  // payload widths
  localparam int TIME_MS_W  = 32;
  localparam int IN_DATA_W  = 40;  // contact, level, prev_level, time_ms, zero padding
  localparam int OUT_DATA_W = 8;   // key_valid, modifier, lit, zero padding

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TMO_W      = 16;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd500;

  // register index, taken from the word address bit
  localparam logic REG_LEAVE_TIMEOUT = 1'b0;

  // input kinds carried on tuser
  localparam logic ACT_CONTACT    = 1'b0;
  localparam logic ACT_TIME_CHECK = 1'b1;

  // contact codes
  localparam logic [1:0] CONTACT_A1 = 2'd0;
  localparam logic [1:0] CONTACT_A2 = 2'd1;
  localparam logic [1:0] CONTACT_I1 = 2'd2;
  localparam logic [1:0] CONTACT_I2 = 2'd3;

  // modifier of an 'l' keystroke
  typedef logic [1:0] mod_t;
  localparam mod_t MOD_NONE  = 2'd0;
  localparam mod_t MOD_SHIFT = 2'd1;
  localparam mod_t MOD_CTRL  = 2'd2;

  // knob positions, one-hot
  typedef enum logic [10:0] {
    ST_UNDEF = 11'b000_0000_0001,
    ST_OFF   = 11'b000_0000_0010,
    ST_WAIT  = 11'b000_0000_0100,
    ST_A1    = 11'b000_0000_1000,
    ST_A1_LV = 11'b000_0001_0000,
    ST_A2    = 11'b000_0010_0000,
    ST_A2_LV = 11'b000_0100_0000,
    ST_I1    = 11'b000_1000_0000,
    ST_I1_LV = 11'b001_0000_0000,
    ST_I2    = 11'b010_0000_0000,
    ST_I2_LV = 11'b100_0000_0000
  } knob_state_t;

  // one result beat
  typedef struct packed {
    logic key_valid;
    mod_t modifier;
    logic lit;
    logic last;
  } result_t;

endpackage

`default_nettype wire

@@ src/light_knob_keystroke_fsm_top.sv @@
// light_knob_keystroke_fsm_top: knob contact tracker issuing 'l' keystroke beats
// single-pass state update with a two-entry result buffer and an apb timeout register
// depends on lkk_pkg
//
// channel  direction  handshake            payload
// in_      slave      tvalid/tready        tuser action, tdata contact/level/prev/time
// out_     master     tvalid/tready        tdata key_valid/modifier/lit, tlast last
// cfg_     apb slave  psel/penable/pready  leave_timeout_ms at byte address 0
//
// an item gives one beat, or two if it causes two keystrokes; the result buffer sends
// one beat per cycle while out_tready is high
// reset (rst_n low, synchronous): knob Undefined, stamp disarmed, timeout 500 ms
// a stalled out_ side holds both buffered beats; in_tready drops once the buffer
// cannot take the results of another item
`default_nettype none

module light_knob_keystroke_fsm_top #(
  parameter int TIME_WIDTH = lkk_pkg::TIME_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // input beats
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [lkk_pkg::IN_DATA_W-1:0]  in_tdata,   // [1:0] contact, [2] level,
                                                     // [3] prev_level, [35:4] time_ms
  input  wire                            in_tuser,   // [0] action
  // result beats
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [lkk_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] key_valid, [2:1] modifier,
                                                     // [3] lit
  output logic                           out_tlast,
  // configuration
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire  [lkk_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [lkk_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lkk_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  import lkk_pkg::*;

  // input fields
  logic                  in_action;
  logic [1:0]            in_contact;
  logic                  in_level;
  logic                  in_prev_level;
  logic [TIME_MS_W-1:0]  in_time_ms;
  logic [TIME_WIDTH-1:0] now;

  // state
  knob_state_t           state_r, state_nxt;
  logic [TIME_WIDTH-1:0] stamp_r, stamp_nxt;
  logic [TMO_W-1:0]      tmo_r;

  // per-item results
  logic                  press_key;
  mod_t                  press_mod;
  logic                  timeout;
  logic                  two_shift;
  logic                  one_shift;
  logic [1:0]            n_keys;
  mod_t                  key0, key1;
  logic                  lit;
  logic [TIME_WIDTH-1:0] elapsed;
  result_t               res0, res1;

  // result buffer
  result_t               slot0_r, slot0_nxt;
  result_t               slot1_r, slot1_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  in_fire, out_fire;

  assign in_action     = in_tuser;
  assign in_contact    = in_tdata[1:0];
  assign in_level      = in_tdata[2];
  assign in_prev_level = in_tdata[3];
  assign in_time_ms    = in_tdata[35:4];
  assign now           = TIME_WIDTH'(in_time_ms);

  // contact handling, then timeout check on the updated stamp
  always_comb begin
    state_nxt = state_r;
    stamp_nxt = stamp_r;
    press_key = 1'b0;
    press_mod = MOD_NONE;
    if (in_action == ACT_CONTACT && in_level != in_prev_level) begin
      if (in_level) begin
        stamp_nxt = '0;
        if (state_r == ST_UNDEF) begin
          state_nxt = ST_WAIT;
        end else begin
          case (in_contact)
            CONTACT_A1: begin
              if (state_r == ST_OFF || state_r == ST_A2 || state_r == ST_A2_LV) begin
                press_key = 1'b1; press_mod = MOD_SHIFT; state_nxt = ST_A1;
              end else if (state_r == ST_I1 || state_r == ST_I1_LV) begin
                press_key = 1'b1; press_mod = MOD_CTRL; state_nxt = ST_A1;
              end
            end
            CONTACT_A2: begin
              if (state_r == ST_A1 || state_r == ST_A1_LV) begin
                press_key = 1'b1; press_mod = MOD_NONE; state_nxt = ST_A2;
              end else if (state_r == ST_I2 || state_r == ST_I2_LV) begin
                press_key = 1'b1; press_mod = MOD_CTRL; state_nxt = ST_A2;
              end
            end
            CONTACT_I1: begin
              if (state_r == ST_A1 || state_r == ST_A1_LV) begin
                press_key = 1'b1; press_mod = MOD_CTRL; state_nxt = ST_I1;
              end else if (state_r == ST_I2 || state_r == ST_I2_LV) begin
                press_key = 1'b1; press_mod = MOD_SHIFT; state_nxt = ST_I1;
              end
            end
            default: begin
              if (state_r == ST_A2 || state_r == ST_A2_LV) begin
                press_key = 1'b1; press_mod = MOD_CTRL; state_nxt = ST_I2;
              end else if (state_r == ST_I1 || state_r == ST_I1_LV) begin
                press_key = 1'b1; press_mod = MOD_NONE; state_nxt = ST_I2;
              end
            end
          endcase
        end
      end else begin
        case (in_contact)
          CONTACT_A1: state_nxt = ST_A1_LV;
          CONTACT_A2: state_nxt = ST_A2_LV;
          CONTACT_I1: state_nxt = ST_I1_LV;
          default:    state_nxt = ST_I2_LV;
        endcase
        stamp_nxt = now;
      end
    end

    // a zero stamp counts as disarmed
    elapsed   = now - stamp_nxt;
    timeout   = (stamp_nxt != '0) && (elapsed > TIME_WIDTH'(tmo_r));
    two_shift = timeout && (state_nxt == ST_A2_LV || state_nxt == ST_I2_LV);
    one_shift = timeout && (state_nxt == ST_A1_LV || state_nxt == ST_I1_LV);

    // keystroke list, at most two entries
    n_keys = 2'd0;
    key0   = MOD_NONE;
    key1   = MOD_NONE;
    if (press_key) begin
      key0   = press_mod;
      n_keys = 2'd1;
    end
    if (two_shift) begin
      if (n_keys == 2'd0) begin
        key0 = MOD_SHIFT; n_keys = 2'd1;
      end else if (n_keys == 2'd1) begin
        key1 = MOD_SHIFT; n_keys = 2'd2;
      end
    end
    if (two_shift || one_shift) begin
      if (n_keys == 2'd0) begin
        key0 = MOD_SHIFT; n_keys = 2'd1;
      end else if (n_keys == 2'd1) begin
        key1 = MOD_SHIFT; n_keys = 2'd2;
      end
    end
    if (timeout) begin
      state_nxt = ST_OFF;
      stamp_nxt = '0;
    end

    lit = !(state_nxt == ST_OFF || state_nxt == ST_UNDEF || state_nxt == ST_WAIT);

    res0.key_valid = (n_keys != 2'd0);
    res0.modifier  = key0;
    res0.lit       = lit;
    res0.last      = (n_keys != 2'd2);
    res1.key_valid = 1'b1;
    res1.modifier  = key1;
    res1.lit       = lit;
    res1.last      = 1'b1;
  end

  // handshakes
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {4'b0000, slot0_r.lit, slot0_r.modifier, slot0_r.key_valid};
  assign out_tlast  = slot0_r.last;

  // result buffer next values
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (in_fire) begin
      slot0_nxt = res0;
      slot1_nxt = res1;
      cnt_nxt   = (n_keys == 2'd2) ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_UNDEF;
      stamp_r <= '0;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
        stamp_r <= stamp_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // timeout register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TMO_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_ADDR_W-1] == REG_LEAVE_TIMEOUT) begin
      tmo_r <= cfg_pwdata[TMO_W-1:0];
    end
  end

  // register read
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_LEAVE_TIMEOUT) ?
                      CFG_DATA_W'(tmo_r) : '0;

endmodule

`default_nettype wire

@@ src/lkk_checker.sv @@
// lkk_checker: port-level checks on the result channel of the knob block
// bound to light_knob_keystroke_fsm_top; depends on lkk_pkg
`default_nettype none

module lkk_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [lkk_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                            out_tlast
);

  import lkk_pkg::*;

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // a beat without a keystroke is alone for its item
  a_nokey_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tlast && out_tdata[2:1] == MOD_NONE)
    else $error("no-key beat is not final or carries a modifier");

  // the second keystroke of an item follows straight away
  a_second_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tdata[0])
    else $error("second keystroke beat missing");

  // a second keystroke is always a shift from a timeout
  a_second_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tdata[2:1] == MOD_SHIFT && out_tlast)
    else $error("second keystroke beat is not a final shift");

endmodule

bind light_knob_keystroke_fsm_top lkk_checker u_lkk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

@@ sim/light_knob_keystroke_fsm_top_tb.sv @@
// light_knob_keystroke_fsm_top_tb: self-checking bench for the light knob keystroke block
// drives contact and time-check beats, predicts keystroke beats and checks them in order
// depends on lkk_pkg and light_knob_keystroke_fsm_top
`timescale 1ns / 100ps

module light_knob_keystroke_fsm_top_tb;
  import lkk_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_ADDR_W-1:0] TMO_ADDR = {REG_LEAVE_TIMEOUT, 2'b00};

  // one directed row: typed beats are used where n_typed > 0
  typedef struct {
    logic        act;
    logic [1:0]  contact;
    logic        lvl;
    logic        prv;
    logic [31:0] stamp_ms;
    int          n_typed;
    result_t     beat0;
    result_t     beat1;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predictor state
  knob_state_t knob_st;
  logic [31:0] leave_stamp;
  logic [15:0] leave_tmo;
  result_t     knob_beats [$];
  result_t     pending_keys [$];

  // run bookkeeping
  int          errors;
  int          n_items;
  int          n_beats;
  int          n_keys;
  int          n_doubles;
  int          n_settings;
  int          idle_in_pct;
  int          stall_out_pct;
  int          quiet_cycles;
  logic [31:0] clock_ms;
  logic        contact_held;
  logic [1:0]  held_contact;
  result_t     got_beat;
  result_t     want_beat;
  stim_row_t   plan [$];

  light_knob_keystroke_fsm_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t beat(input logic kv, input mod_t m, input logic lit,
                                   input logic last);
    result_t b;
    b.key_valid = kv;
    b.modifier  = m;
    b.lit       = lit;
    b.last      = last;
    return b;
  endfunction

  function automatic stim_row_t row(input logic act, input logic [1:0] c, input logic lvl,
                                    input logic prv, input logic [31:0] t, input int n,
                                    input result_t b0, input result_t b1);
    stim_row_t r;
    r.act      = act;
    r.contact  = c;
    r.lvl      = lvl;
    r.prv      = prv;
    r.stamp_ms = t;
    r.n_typed  = n;
    r.beat0    = b0;
    r.beat1    = b1;
    return r;
  endfunction

  // knob tracker: updates state and fills knob_beats with the beats of one item
  function automatic void step_knob(input logic act, input logic [1:0] c, input logic lvl,
                                    input logic prv, input logic [31:0] t);
    mod_t keys [$];
    logic lit;
    logic leaving;
    keys = {};
    if (act == ACT_CONTACT && lvl != prv) begin
      if (lvl) begin
        // press: step to the new position where a transition exists
        if (knob_st == ST_UNDEF) begin
          knob_st = ST_WAIT;
        end else begin
          case (c)
            CONTACT_A1: begin
              case (knob_st)
                ST_OFF, ST_A2, ST_A2_LV: begin keys.push_back(MOD_SHIFT); knob_st = ST_A1; end
                ST_I1, ST_I1_LV:         begin keys.push_back(MOD_CTRL);  knob_st = ST_A1; end
                default: ;
              endcase
            end
            CONTACT_A2: begin
              case (knob_st)
                ST_A1, ST_A1_LV: begin keys.push_back(MOD_NONE); knob_st = ST_A2; end
                ST_I2, ST_I2_LV: begin keys.push_back(MOD_CTRL); knob_st = ST_A2; end
                default: ;
              endcase
            end
            CONTACT_I1: begin
              case (knob_st)
                ST_A1, ST_A1_LV: begin keys.push_back(MOD_CTRL);  knob_st = ST_I1; end
                ST_I2, ST_I2_LV: begin keys.push_back(MOD_SHIFT); knob_st = ST_I1; end
                default: ;
              endcase
            end
            default: begin
              case (knob_st)
                ST_A2, ST_A2_LV: begin keys.push_back(MOD_CTRL); knob_st = ST_I2; end
                ST_I1, ST_I1_LV: begin keys.push_back(MOD_NONE); knob_st = ST_I2; end
                default: ;
              endcase
            end
          endcase
        end
        leave_stamp = '0;
      end else begin
        // release: enter that position's leaving state and stamp the time
        case (c)
          CONTACT_A1: knob_st = ST_A1_LV;
          CONTACT_A2: knob_st = ST_A2_LV;
          CONTACT_I1: knob_st = ST_I1_LV;
          default:    knob_st = ST_I2_LV;
        endcase
        leave_stamp = t;
      end
    end

    // leaving timeout, a zero stamp counts as disarmed
    if (leave_stamp != '0 && (t - leave_stamp) > {16'b0, leave_tmo}) begin
      leaving = 1'b0;
      case (knob_st)
        ST_A2_LV, ST_I2_LV: begin
          if (keys.size() < 2) keys.push_back(MOD_SHIFT);
          leaving = 1'b1;
        end
        ST_A1_LV, ST_I1_LV: leaving = 1'b1;
        default: ;
      endcase
      if (leaving && keys.size() < 2) keys.push_back(MOD_SHIFT);
      knob_st     = ST_OFF;
      leave_stamp = '0;
    end

    case (knob_st)
      ST_OFF, ST_UNDEF, ST_WAIT: lit = 1'b0;
      default:                   lit = 1'b1;
    endcase

    knob_beats = {};
    if (keys.size() == 0) begin
      knob_beats.push_back(beat(1'b0, MOD_NONE, lit, 1'b1));
    end else begin
      foreach (keys[k]) knob_beats.push_back(beat(1'b1, keys[k], lit, k == keys.size() - 1));
    end
  endfunction

  // present one beat on the input side and log its expected results once taken
  task automatic send_item(input stim_row_t r);
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.act;
    in_tdata  <= {4'b0, r.stamp_ms, r.prv, r.lvl, r.contact};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_knob(r.act, r.contact, r.lvl, r.prv, r.stamp_ms);
    if (r.n_typed > 0) begin
      pending_keys.push_back(r.beat0);
      if (r.n_typed > 1) pending_keys.push_back(r.beat1);
    end else begin
      foreach (knob_beats[k]) pending_keys.push_back(knob_beats[k]);
    end
    n_items++;
    if (knob_beats.size() > 1) n_doubles++;
    @(negedge clk);
  endtask

  // hold off the sender until every expected beat has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write the leave timeout, then read it back
  task automatic write_leave_timeout(input logic [15:0] ms);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TMO_ADDR;
    cfg_pwdata  <= {16'b0, ms};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    leave_tmo   = ms;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {16'b0, ms}) begin
      errors++;
      $display("%0t ns: leave timeout read back, expected %0d, got %0d",
               $time, ms, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    n_settings++;
  endtask

  // random traffic: mostly press and release pairs with time steps around the timeout
  task automatic run_random(input int count);
    int        pick;
    int        span;
    stim_row_t r;
    for (int i = 0; i < count; i++) begin
      span = int'(leave_tmo);
      case ($urandom_range(0, 19))
        0:       clock_ms = $urandom;
        1:       clock_ms = '0;
        2, 3, 4: clock_ms = clock_ms + $urandom_range(0, 200000);
        5, 6, 7, 8, 9:
          clock_ms = clock_ms + $urandom_range((span > 4) ? span - 4 : 0, span + 4);
        default: clock_ms = clock_ms + $urandom_range(0, span / 2 + 3);
      endcase
      pick = $urandom_range(0, 99);
      r = row(ACT_CONTACT, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0,
              clock_ms, 0, '0, '0);
      r.prv = ~r.lvl;
      if (pick < 12) begin
        // time check with junk in the ignored fields
        r.act = ACT_TIME_CHECK;
        r.prv = 1'($urandom_range(0, 1));
      end else if (pick < 20) begin
        // contact bounce that changes nothing
        r.prv = r.lvl;
      end else if (contact_held && pick < 80) begin
        r.contact = held_contact;
        r.lvl     = 1'b0;
        r.prv     = 1'b1;
      end else if (!contact_held && pick < 90) begin
        r.lvl = 1'b1;
        r.prv = 1'b0;
      end
      if (r.act == ACT_CONTACT && r.lvl != r.prv) begin
        contact_held = r.lvl;
        held_contact = r.contact;
      end
      send_item(r);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = beat(out_tdata[0], out_tdata[2:1], out_tdata[3], out_tlast);
      n_beats++;
      if (got_beat.key_valid) n_keys++;
      if (pending_keys.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing expected: kv=%0b mod=%0d lit=%0b last=%0b",
                 $time, got_beat.key_valid, got_beat.modifier, got_beat.lit, got_beat.last);
      end else begin
        want_beat = pending_keys.pop_front();
        if (got_beat.key_valid !== want_beat.key_valid || got_beat.modifier !== want_beat.modifier
            || got_beat.lit !== want_beat.lit || got_beat.last !== want_beat.last) begin
          errors++;
          $display("%0t ns: result mismatch, expected kv=%0b mod=%0d lit=%0b last=%0b, got kv=%0b mod=%0d lit=%0b last=%0b",
                   $time, want_beat.key_valid, want_beat.modifier, want_beat.lit,
                   want_beat.last, got_beat.key_valid, got_beat.modifier, got_beat.lit,
                   got_beat.last);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_out_pct);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    out_tready    = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    knob_st       = ST_UNDEF;
    leave_stamp   = '0;
    leave_tmo     = TMO_RESET;
    errors        = 0;
    n_items       = 0;
    n_beats       = 0;
    n_keys        = 0;
    n_doubles     = 0;
    n_settings    = 0;
    idle_in_pct   = 0;
    stall_out_pct = 0;
    quiet_cycles  = 0;
    clock_ms      = 32'd10000;
    contact_held  = 1'b0;
    held_contact  = CONTACT_A1;

    // directed walk from reset, timeout at its reset value
    plan.push_back(row(ACT_TIME_CHECK, CONTACT_A1, 1'b0, 1'b0, 32'd0, 1,
                       beat(1'b0, MOD_NONE, 1'b0, 1'b1), '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b1, 1'b0, 32'd10, 1,
                       beat(1'b0, MOD_NONE, 1'b0, 1'b1), '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b1, 1'b0, 32'd15, 1,
                       beat(1'b0, MOD_NONE, 1'b0, 1'b1), '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b0, 1'b1, 32'd20, 1,
                       beat(1'b0, MOD_NONE, 1'b1, 1'b1), '0));
    // exactly at the timeout nothing happens, one past it the knob drops to off
    plan.push_back(row(ACT_TIME_CHECK, CONTACT_A1, 1'b0, 1'b0, 32'd520, 1,
                       beat(1'b0, MOD_NONE, 1'b1, 1'b1), '0));
    plan.push_back(row(ACT_TIME_CHECK, CONTACT_A1, 1'b0, 1'b0, 32'd521, 1,
                       beat(1'b1, MOD_SHIFT, 1'b0, 1'b1), '0));
    // every press transition but the step from A2 to A1, in turn
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b1, 1'b0, 32'd600, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A2, 1'b1, 1'b0, 32'd610, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A2, 1'b0, 1'b1, 32'd1000, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_I2, 1'b1, 1'b0, 32'd1100, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_I1, 1'b1, 1'b0, 32'd1200, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b1, 1'b0, 32'd1300, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_I1, 1'b1, 1'b0, 32'd1400, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_I2, 1'b1, 1'b0, 32'd1500, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A2, 1'b1, 1'b0, 32'd1600, 0, '0, '0));
    // events with no level change
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b1, 1'b1, 32'd1700, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A2, 1'b0, 1'b0, 32'd1701, 0, '0, '0));
    // leave I2 just before the time wraps, double shift after the wrap
    plan.push_back(row(ACT_CONTACT, CONTACT_I2, 1'b0, 1'b1, 32'hFFFF_FF00, 0, '0, '0));
    plan.push_back(row(ACT_TIME_CHECK, CONTACT_I2, 1'b1, 1'b0, 32'h0000_0200, 2,
                       beat(1'b1, MOD_SHIFT, 1'b0, 1'b0), beat(1'b1, MOD_SHIFT, 1'b0, 1'b1)));
    // release at time zero never arms the timeout
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b1, 1'b0, 32'h0000_0300, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_A1, 1'b0, 1'b1, 32'd0, 1,
                       beat(1'b0, MOD_NONE, 1'b1, 1'b1), '0));
    plan.push_back(row(ACT_TIME_CHECK, CONTACT_A1, 1'b0, 1'b0, 32'hFFFF_FFFF, 1,
                       beat(1'b0, MOD_NONE, 1'b1, 1'b1), '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_I1, 1'b1, 1'b0, 32'd5, 0, '0, '0));
    plan.push_back(row(ACT_CONTACT, CONTACT_I1, 1'b0, 1'b1, 32'd100, 0, '0, '0));
    plan.push_back(row(ACT_TIME_CHECK, CONTACT_A1, 1'b0, 1'b0, 32'd601, 0, '0, '0));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (plan[i]) send_item(plan[i]);

    // random phases, each with its own timeout, cycling through four idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0:       write_leave_timeout(16'd0);
        1:       write_leave_timeout(16'hFFFF);
        2:       write_leave_timeout(16'd1);
        3:       write_leave_timeout(16'($urandom_range(2, 3000)));
        4:       write_leave_timeout(TMO_RESET);
        default: write_leave_timeout(16'd37);
      endcase
      case (ph % 4)
        0:       begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1:       begin idle_in_pct = 71; stall_out_pct = 0;  end
        2:       begin idle_in_pct = 0;  stall_out_pct = 71; end
        default: begin idle_in_pct = 24; stall_out_pct = 24; end
      endcase
      run_random(130);
      if (ph == 2) drain_results();
      run_random(130);
    end

    // let the last beats out
    idle_in_pct   = 0;
    stall_out_pct = 0;
    drain_results();
    repeat (12) @(negedge clk);

    $display("covered %0d items and %0d result beats, %0d of them keystrokes, %0d items with two",
             n_items, n_beats, n_keys, n_doubles);
    $display("over %0d timeout settings and four idling patterns, %0d mismatches",
             n_settings, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
